@@ hdl/lpmf_pkg.sv @@
// ----------------------------------------------------------------------------
// lpmf_pkg
// Shared constants, register indexes, the pipeline word type and the fixed
// point helpers of the lidar point mask filter.
// ----------------------------------------------------------------------------
package lpmf_pkg;

  localparam int NS = 18;

  localparam logic [2:0] REG_MAX_RANGE = 3'd0;
  localparam logic [2:0] REG_ROBOT_XMIN = 3'd1;
  localparam logic [2:0] REG_ROBOT_XMAX = 3'd2;
  localparam logic [2:0] REG_ROBOT_YMIN = 3'd3;
  localparam logic [2:0] REG_ROBOT_YMAX = 3'd4;

  localparam logic [14:0] ANG_LO = 15'd5760;
  localparam logic [14:0] ANG_HI = 15'd17280;
  localparam logic [14:0] ANG_HALF = 15'd11520;
  localparam logic [14:0] ANG_EIGHTH = 15'd2880;
  localparam logic [14:0] ANG_QUARTER = 15'd5760;
  localparam logic [18:0] RAD_PER_UNIT = 19'd292818;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  localparam logic [63:0] TWO32 = 64'h1_0000_0000;
  localparam logic [31:0] RECIP_42 = 32'(TWO32 / 64'd42);
  localparam logic [31:0] RECIP_56 = 32'(TWO32 / 64'd56);
  localparam logic [31:0] RECIP_20 = 32'(TWO32 / 64'd20);
  localparam logic [31:0] RECIP_30 = 32'(TWO32 / 64'd30);
  localparam logic [31:0] RECIP_6 = 32'(TWO32 / 64'd6);
  localparam logic [31:0] RECIP_12 = 32'(TWO32 / 64'd12);

  typedef struct packed {
    logic [15:0] rng;
    logic endm;
    logic rej;
    logic neg;
    logic swap;
    logic [11:0] w;
    logic [29:0] t;
    logic [29:0] t2;
    logic [29:0] qs;
    logic [29:0] qc;
    logic [30:0] sa;
    logic [30:0] ca;
    logic [29:0] ps;
    logic [29:0] pc;
    logic [14:0] sq;
    logic [14:0] cq;
    logic [16:0] xm;
    logic [16:0] ym;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic box;
    logic signed [18:0] dx;
    logic signed [18:0] d0;
    logic signed [18:0] d1;
    logic [32:0] dx2;
    logic [32:0] d0q;
    logic [32:0] d1q;
    logic keep;
    logic [11:0] xo;
    logic [11:0] yo;
  } pipe_t;

  // q30 product of a q30 value and a q30 coefficient
  function automatic logic [29:0] mul_q30(input logic [29:0] a, input logic [30:0] b);
    logic [60:0] p;
    p = 61'(a) * 61'(b);
    return p[59:30];
  endfunction

  // estimate of x / d, low by at most one
  function automatic logic [29:0] mul_recip(input logic [29:0] x, input logic [31:0] m);
    logic [61:0] p;
    p = 62'(x) * 62'(m);
    return p[61:32];
  endfunction

  function automatic logic [29:0] div_fix(input logic [29:0] x, input logic [29:0] q0,
                                          input logic [6:0] d);
    logic [36:0] prod;
    logic [36:0] rem;
    prod = 37'(q0) * 37'(d);
    rem = 37'(x) - prod;
    return (rem >= 37'(d)) ? q0 + 30'd1 : q0;
  endfunction

  function automatic logic [14:0] to_q15(input logic [30:0] v);
    logic [31:0] r;
    r = (32'(v) + 32'd16384) >> 15;
    return (r > 32'd32767) ? 15'd32767 : r[14:0];
  endfunction

  function automatic logic [11:0] sat12(input logic signed [17:0] v);
    if (v > 18'sd2047) begin
      return 12'h7ff;
    end else if (v < -18'sd2048) begin
      return 12'h800;
    end
    return v[11:0];
  endfunction

endpackage

@@ hdl/lidar_point_mask_filter.sv @@
// ----------------------------------------------------------------------------
// lidar_point_mask_filter
// Range and angle gate, polar to robot frame conversion and mask tests.
// ----------------------------------------------------------------------------
// One return enters per cycle unless stage 0 is held; results leave in order.
// The depth is set by the sine and cosine series, where each term takes a
// multiply, a reciprocal multiply and a correction stage. Every stage has its
// own valid bit and holds only when the stage after it is full and held, so a
// stalled output does not stop the input while bubbles remain. The user must
// write configuration via cfg_we, cfg_addr and cfg_wdata only while no word
// is in flight, unenforced; addresses past the last register are ignored.
module lidar_point_mask_filter (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [2:0] cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic in_valid,
  output logic in_ready,
  input  logic [14:0] angle,
  input  logic [15:0] range_mm,
  input  logic scan_end,
  output logic out_valid,
  input  logic out_ready,
  output logic keep,
  output logic signed [11:0] x_mm,
  output logic signed [11:0] y_mm,
  output logic scan_end_out
);
  import lpmf_pkg::*;

  logic [15:0] max_range_mm;
  logic signed [15:0] robot_x_min;
  logic signed [15:0] robot_x_max;
  logic signed [15:0] robot_y_min;
  logic signed [15:0] robot_y_max;

  pipe_t st [NS];
  pipe_t st_next [NS];
  logic [NS-1:0] v;
  logic [NS-1:0] ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_range_mm <= 16'd500;
      robot_x_min <= '0;
      robot_x_max <= '0;
      robot_y_min <= '0;
      robot_y_max <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MAX_RANGE: max_range_mm <= cfg_wdata;
        REG_ROBOT_XMIN: robot_x_min <= cfg_wdata;
        REG_ROBOT_XMAX: robot_x_max <= cfg_wdata;
        REG_ROBOT_YMIN: robot_y_min <= cfg_wdata;
        REG_ROBOT_YMAX: robot_y_max <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a stage may load when empty or when its word moves on
  always_comb begin
    ce[NS-1] = !v[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      ce[i] = !v[i] || ce[i+1];
    end
  end

  assign in_ready = ce[0];

  always_comb begin
    logic [14:0] a;
    logic signed [37:0] sqx;
    logic signed [37:0] sq0;
    logic signed [37:0] sq1;
    logic circ;

    // stage 0: gate and fold the angle into 0..45 degrees
    st_next[0] = '0;
    st_next[0].rng = range_mm;
    st_next[0].endm = scan_end;
    st_next[0].rej = (range_mm > max_range_mm) || (angle < ANG_LO) || (angle > ANG_HI);
    st_next[0].neg = angle < ANG_HALF;
    a = (angle >= ANG_HALF) ? angle - ANG_HALF : ANG_HALF - angle;
    st_next[0].swap = a > ANG_EIGHTH;
    st_next[0].w = (a > ANG_EIGHTH) ? 12'(ANG_QUARTER - a) : a[11:0];

    st_next[1] = st[0];
    st_next[1].t = 30'(31'(st[0].w) * 31'(RAD_PER_UNIT));

    st_next[2] = st[1];
    st_next[2].t2 = mul_q30(st[1].t, 31'(st[1].t));

    // first series term
    st_next[3] = st[2];
    st_next[3].qs = mul_recip(st[2].t2, RECIP_42);
    st_next[3].qc = mul_recip(st[2].t2, RECIP_56);

    st_next[4] = st[3];
    st_next[4].sa = Q30_ONE - 31'(div_fix(st[3].t2, st[3].qs, 7'd42));
    st_next[4].ca = Q30_ONE - 31'(div_fix(st[3].t2, st[3].qc, 7'd56));

    // second term
    st_next[5] = st[4];
    st_next[5].ps = mul_q30(st[4].t2, st[4].sa);
    st_next[5].pc = mul_q30(st[4].t2, st[4].ca);

    st_next[6] = st[5];
    st_next[6].qs = mul_recip(st[5].ps, RECIP_20);
    st_next[6].qc = mul_recip(st[5].pc, RECIP_30);

    st_next[7] = st[6];
    st_next[7].sa = Q30_ONE - 31'(div_fix(st[6].ps, st[6].qs, 7'd20));
    st_next[7].ca = Q30_ONE - 31'(div_fix(st[6].pc, st[6].qc, 7'd30));

    // third term
    st_next[8] = st[7];
    st_next[8].ps = mul_q30(st[7].t2, st[7].sa);
    st_next[8].pc = mul_q30(st[7].t2, st[7].ca);

    st_next[9] = st[8];
    st_next[9].qs = mul_recip(st[8].ps, RECIP_6);
    st_next[9].qc = mul_recip(st[8].pc, RECIP_12);

    st_next[10] = st[9];
    st_next[10].sa = Q30_ONE - 31'(div_fix(st[9].ps, st[9].qs, 7'd6));
    st_next[10].ca = Q30_ONE - 31'(div_fix(st[9].pc, st[9].qc, 7'd12));

    // sine closes with t, cosine takes one more term
    st_next[11] = st[10];
    st_next[11].ps = mul_q30(st[10].t, st[10].sa);
    st_next[11].pc = mul_q30(st[10].t2, st[10].ca);

    st_next[12] = st[11];
    st_next[12].sq = to_q15({1'b0, st[11].ps});
    st_next[12].ca = Q30_ONE - 31'(st[11].pc >> 1);

    // above 45 degrees sine and cosine trade places
    st_next[13] = st[12];
    st_next[13].sq = st[12].swap ? to_q15(st[12].ca) : st[12].sq;
    st_next[13].cq = st[12].swap ? st[12].sq : to_q15(st[12].ca);

    st_next[14] = st[13];
    st_next[14].xm = 17'((32'(st[13].rng) * 32'(st[13].cq) + 32'd16384) >> 15);
    st_next[14].ym = 17'((32'(st[13].rng) * 32'(st[13].sq) + 32'd16384) >> 15);

    st_next[15] = st[14];
    st_next[15].x = 18'sd220 + $signed({1'b0, st[14].xm});
    st_next[15].y = st[14].neg ? $signed({1'b0, st[14].ym}) : -$signed({1'b0, st[14].ym});
    st_next[15].box =
      (st_next[15].x > robot_x_min && st_next[15].x < robot_x_max &&
       st_next[15].y > robot_y_min && st_next[15].y < robot_y_max) ||
      (st_next[15].x > 18'sd0 && st_next[15].x < 18'sd400 &&
       st_next[15].y > -18'sd20000 && st_next[15].y < 18'sd20000);
    st_next[15].dx = 19'(st_next[15].x) - 19'sd300;
    st_next[15].d0 = 19'(st_next[15].y) - 19'sd150;
    st_next[15].d1 = 19'(st_next[15].y) + 19'sd150;

    st_next[16] = st[15];
    sqx = st[15].dx * st[15].dx;
    sq0 = st[15].d0 * st[15].d0;
    sq1 = st[15].d1 * st[15].d1;
    st_next[16].dx2 = sqx[32:0];
    st_next[16].d0q = sq0[32:0];
    st_next[16].d1q = sq1[32:0];

    st_next[17] = st[16];
    circ = (34'(st[16].dx2) + 34'(st[16].d0q) < 34'd2500) ||
           (34'(st[16].dx2) + 34'(st[16].d1q) < 34'd2500);
    st_next[17].keep = !st[16].rej && !st[16].box && !circ;
    st_next[17].xo = st_next[17].keep ? sat12(st[16].x) : 12'd0;
    st_next[17].yo = st_next[17].keep ? sat12(st[16].y) : 12'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ce[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (ce[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (ce[i]) begin
        st[i] <= st_next[i];
      end
    end
  end

  assign out_valid = v[NS-1];
  assign keep = st[NS-1].keep;
  assign x_mm = st[NS-1].xo;
  assign y_mm = st[NS-1].yo;
  assign scan_end_out = st[NS-1].endm;

endmodule

@@ hdl/lpmf_checker.sv @@
// ----------------------------------------------------------------------------
// lpmf_checker
// Port level checks of the lidar point mask filter, bound to the top level.
// ----------------------------------------------------------------------------
module lpmf_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic keep,
  input logic signed [11:0] x_mm,
  input logic signed [11:0] y_mm
);

  // a held word stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // rejected words carry zero coordinates
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !keep |-> x_mm == 12'sd0 && y_mm == 12'sd0)
    else $error("rejected word with nonzero coordinates");

  // kept points never lie behind the mount offset in x
  a_keep_x: assert property (@(posedge clk) disable iff (rst)
    out_valid && keep |-> x_mm >= 12'sd220)
    else $error("kept point behind the mount offset");

endmodule

bind lidar_point_mask_filter lpmf_checker u_lpmf_checker (.*);
